// ===== hw/rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared constants, codes and types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ECNT_W  = 7;
  localparam int unsigned STAT_W  = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  // Broadcast from the controller to every cell in the row.
  typedef struct packed {
    cell_op_e op;
    word_t    value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/hpq_cell.sv =====
// ----------------------------------------------------------------------------
// hpq_cell
// One slot of the sorted row: holds one word, compares it with the broadcast
// insert value and trades words with its neighbours.
// ----------------------------------------------------------------------------
module hpq_cell (
  input  logic               clk_i,
  input  hpq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               prev_ge_i,
  input  hpq_pkg::word_t     prev_word_i,
  input  hpq_pkg::word_t     next_word_i,
  output hpq_pkg::word_t     word_o,
  output logic               ge_o
);
  import hpq_pkg::*;

  word_t word_q, word_d;

  // Occupied slot that stays ahead of the new value.
  assign ge_o   = occupied_i && (word_q >= ctrl_i.value);
  assign word_o = word_q;

  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (ge_o) begin
          word_d = word_q;
        end else if (prev_ge_i) begin
          word_d = ctrl_i.value;
        end else begin
          word_d = prev_word_i;
        end
      end
      OP_REMOVE: word_d = next_word_i;
      default:   word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Priority queue of signed words that always yields its largest entry.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one beat with kind_i and
// value_i. Kind insert adds value_i; kind remove takes out the largest entry.
// Output channel: out_valid_o / out_stall_i carry one result beat per input
// beat: removed_value_o, top_value_o (largest entry left, 0 when empty),
// entry_count_o and status_o (done, insert refused as full, remove on empty).
// The result beat is presented on the cycle after the input beat is taken.
// Throughput is one beat per cycle while no result waits under out_stall_i,
// set by the row of cells, which keeps the entries sorted largest first, shifts
// the entries below an insert right and shifts the whole row left on a remove.
// While a result waits under out_stall_i, in_stall_o is raised; the held
// result does not change and a new beat is taken in the cycle it leaves.
// Reset empties the queue and the output register at once; the cell words
// themselves are not cleared, only slots below the entry count are looked at.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  hpq_pkg::word_t                value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hpq_pkg::word_t                removed_value_o,
  output hpq_pkg::word_t                top_value_o,
  output logic [hpq_pkg::ECNT_W-1:0]    entry_count_o,
  output logic [hpq_pkg::STAT_W-1:0]    status_o
);
  import hpq_pkg::*;

  // Row state, count and the result register.
  count_t     count_q, count_d;
  logic       out_valid_q, out_valid_d;
  word_t      removed_q, removed_d;
  word_t      top_q, top_d;
  count_t     out_count_q, out_count_d;
  status_e    status_q, status_d;

  logic       accept;
  kind_e      kind;
  cell_ctrl_t ctrl;

  word_t      cell_word [DEPTH];
  logic       cell_ge   [DEPTH];
  logic       cell_occ  [DEPTH];

  logic [CNT_W+ECNT_W-1:0] count_wide;

  // Hold the input while a result still waits downstream.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = kind_e'(kind_i);

  // Work out the step and the result from the row as it stands.
  always_comb begin
    count_d       = count_q;
    ctrl.op       = OP_HOLD;
    ctrl.value    = value_i;
    removed_d     = removed_q;
    top_d         = top_q;
    out_count_d   = out_count_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q && out_stall_i;

    if (accept) begin
      out_valid_d = 1'b1;
      removed_d   = '0;
      status_d    = ST_DONE;
      top_d       = (count_q != '0) ? cell_word[0] : '0;
      unique case (kind)
        KIND_INSERT: begin
          if (count_q == count_t'(DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = OP_INSERT;
            count_d = count_q + count_t'(1);
            if (count_q == '0 || value_i > cell_word[0]) begin
              top_d = value_i;
            end
          end
        end
        KIND_REMOVE: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op   = OP_REMOVE;
            count_d   = count_q - count_t'(1);
            removed_d = cell_word[0];
            top_d     = (count_q > count_t'(1)) ? cell_word[1] : '0;
          end
        end
        default: status_d = ST_DONE;
      endcase
      out_count_d = count_d;
    end
  end

  // Row of cells: the leftmost slot holds the largest entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  prev_ge;
    word_t prev_word;
    word_t next_word;

    assign cell_occ[i] = (count_q > count_t'(i));

    if (i == 0) begin : g_head
      assign prev_ge   = 1'b1;
      assign prev_word = value_i;
    end else begin : g_body
      assign prev_ge   = cell_ge[i-1];
      assign prev_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_word = cell_word[i];
    end else begin : g_mid
      assign next_word = cell_word[i+1];
    end

    hpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (cell_occ[i]),
      .prev_ge_i   (prev_ge),
      .prev_word_i (prev_word),
      .next_word_i (next_word),
      .word_o      (cell_word[i]),
      .ge_o        (cell_ge[i])
    );
  end

  // Control state clears on reset; payload registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q   <= removed_d;
    top_q       <= top_d;
    out_count_q <= out_count_d;
    status_q    <= status_d;
  end

  // Report the count in the low bits of the field.
  assign count_wide      = {{ECNT_W{1'b0}}, out_count_q};
  assign entry_count_o   = count_wide[ECNT_W-1:0];
  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign top_value_o     = top_q;
  assign status_o        = status_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the max-heap priority queue. A shadow heap predicts
// removed value, largest entry, count and status for every input beat; result
// beats are compared field by field in order. Directed beats cover the word
// extremes, equal keys and the empty case, then random runs of fill, drain
// and churn sweep the count between empty and full under random idling.
// ----------------------------------------------------------------------------
module testbench;
  import hpq_pkg::*;

  // One predicted result beat.
  typedef struct {
    word_t                removed;
    word_t                top;
    logic [ECNT_W-1:0]    count;
    status_e              status;
  } heap_result_t;

  // Shadow of the queue: a plain binary max-heap plus the results still owed.
  class heap_shadow;
    word_t          slots[DEPTH];
    int unsigned    held;
    heap_result_t   awaited[$];
    int unsigned    failures;
    int unsigned    n_insert, n_remove, n_full, n_empty, n_checked, peak;

    function new();
      held = 0;
      failures = 0;
      n_insert = 0;
      n_remove = 0;
      n_full = 0;
      n_empty = 0;
      n_checked = 0;
      peak = 0;
    endfunction

    // Apply one accepted input beat and queue the result it must produce.
    function void note_beat(kind_e k, word_t v);
      heap_result_t r;
      int unsigned  pos, parent, big, lc, rc;
      word_t        t;
      r.removed = '0;
      r.status  = ST_DONE;
      if (k == KIND_INSERT) begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // Sift up from the first free slot; stop at an equal parent.
          pos = held;
          while (pos >= 1) begin
            parent = (pos - 1) / 2;
            if (!(v > slots[parent])) break;
            slots[pos] = slots[parent];
            pos = parent;
          end
          slots[pos] = v;
          held++;
          n_insert++;
          if (held > peak) peak = held;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.removed = slots[0];
          held--;
          slots[0] = slots[held];
          // Sift down towards the strictly larger child.
          pos = 0;
          forever begin
            big = pos;
            lc  = 2 * pos + 1;
            rc  = 2 * pos + 2;
            if (lc < held && slots[lc] > slots[big]) big = lc;
            if (rc < held && slots[rc] > slots[big]) big = rc;
            if (big == pos) break;
            t          = slots[pos];
            slots[pos] = slots[big];
            slots[big] = t;
            pos        = big;
          end
          n_remove++;
        end
      end
      r.top   = (held != 0) ? slots[0] : '0;
      r.count = ECNT_W'(held);
      awaited = {awaited, r};
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_beat(word_t removed, word_t top, logic [ECNT_W-1:0] count,
                             logic [STAT_W-1:0] st);
      heap_result_t r;
      if (awaited.size() == 0) begin
        $error("result beat with no input beat outstanding");
        failures++;
        return;
      end
      r = awaited[0];
      awaited.delete(0);
      n_checked++;
      if (removed !== r.removed) begin
        $error("removed_value: expected %0d, got %0d", r.removed, removed);
        failures++;
      end
      if (top !== r.top) begin
        $error("top_value: expected %0d, got %0d", r.top, top);
        failures++;
      end
      if (count !== r.count) begin
        $error("entry_count: expected %0d, got %0d", r.count, count);
        failures++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        failures++;
      end
    endfunction

    function int unsigned owed();
      return awaited.size();
    endfunction
  endclass

  // Clock, reset and the block's ports; every input known from time zero.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              kind_i      = KIND_INSERT;
  word_t             value_i     = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  word_t             removed_value_o;
  word_t             top_value_o;
  logic [ECNT_W-1:0] entry_count_o;
  logic [STAT_W-1:0] status_o;

  heap_shadow  shadow;
  int unsigned sender_idle_pct = 25;  // chance per cycle that the sender rests
  int unsigned sink_stall_pct  = 25;  // chance per cycle that the sink stalls
  int unsigned holdoff_left    = 0;   // cycles of forced stall still to run
  int unsigned beats_sent      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  max_heap_priority_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .top_value_o     (top_value_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  // Result side: drive the stall on the falling edge. A hold-off request
  // forces the stall high for its full length and is counted down here.
  always @(negedge clk_i) begin
    if (holdoff_left != 0) begin
      out_stall_i  <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Sample result beats on the rising edge and check them in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      shadow.check_beat(removed_value_o, top_value_o, entry_count_o, status_o);
    end
  end

  // Offer one input beat from a falling edge; hold it until taken, note it in
  // the shadow at the accepting edge and return on the next falling edge.
  task automatic send_beat(input kind_e k, input word_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_i    <= v;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    shadow.note_beat(k, v);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (shadow.owed() != 0) @(negedge clk_i);
  endtask

  // Mix of full-range words, a narrow band that forces equal keys, and the
  // extremes of the signed range.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      5, 6:    return word_t'($signed($urandom_range(8)) - 4);
      7: begin
        case ($urandom_range(3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic kind_e pick_kind(int unsigned insert_pct);
    return ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
  endfunction

  // Hang guard.
  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int unsigned phase_len, insert_pct;
    shadow = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: remove on empty, word extremes, equal keys, drain past empty.
    send_beat(KIND_REMOVE, 32'sh1234_5678);
    send_beat(KIND_INSERT, 32'sh7FFF_FFFF);
    send_beat(KIND_INSERT, 32'sh8000_0000);
    send_beat(KIND_INSERT, '0);
    send_beat(KIND_INSERT, -32'sd1);
    send_beat(KIND_INSERT, 32'sd1);
    send_beat(KIND_INSERT, 32'sd7);
    send_beat(KIND_INSERT, 32'sd7);
    send_beat(KIND_INSERT, 32'sd7);
    send_beat(KIND_INSERT, 32'sh8000_0000);
    repeat (10) send_beat(KIND_REMOVE, pick_word());
    drain_results();

    // Fill past full with no sender idling while the sink holds off for a
    // long stretch, so the block backs up and stalls its input.
    sender_idle_pct = 0;
    holdoff_left    = 60;
    repeat (DEPTH + 6) send_beat(KIND_INSERT, pick_word());
    sender_idle_pct = 25;
    drain_results();
    repeat (DEPTH + 6) send_beat(KIND_REMOVE, pick_word());

    // A long quiet stretch: neither side idles.
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (120) send_beat(pick_kind(60), pick_word());
    sender_idle_pct = 25;
    sink_stall_pct  = 25;

    // Random runs that grow, shrink or churn the heap, sweeping the count
    // between empty and full; pause for a full drain now and then.
    while (beats_sent < 675) begin
      phase_len = $urandom_range(90, 20);
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      repeat (phase_len) send_beat(pick_kind(insert_pct), pick_word());
      if ($urandom_range(3) == 0) drain_results();
    end

    // Wait out the owed results, then allow for any stray beat.
    drain_results();
    repeat (40) @(negedge clk_i);
    if (shadow.owed() != 0) begin
      $error("%0d result beats never arrived", shadow.owed());
      shadow.failures++;
    end

    $display("Checked %0d result beats: %0d inserts, %0d removes, peak count %0d.",
             shadow.n_checked, shadow.n_insert, shadow.n_remove, shadow.peak);
    $display("Refused inserts on a full heap: %0d; removes on an empty heap: %0d.",
             shadow.n_full, shadow.n_empty);
    if (shadow.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
